// ----- src/ntc_pkg.sv -----
package ntc_pkg;

	// register file
	localparam int CFG_W     = 20;
	localparam int CFG_IDX_W = 3;
	localparam int MV_W      = 13;
	localparam int OHM_W     = 20;

	localparam logic [MV_W-1:0]  FULL_SCALE_RST = MV_W'(4096);
	localparam logic [MV_W-1:0]  SUPPLY_RST     = MV_W'(3300);
	localparam logic [OHM_W-1:0] SERIES_RST     = OHM_W'(4700);
	localparam logic [OHM_W-1:0] NOMINAL_RST    = OHM_W'(10000);
	localparam logic [MV_W-1:0]  BETA_RST       = MV_W'(3625);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FULL_SCALE,
		CFG_SUPPLY,
		CFG_SERIES,
		CFG_NOMINAL,
		CFG_BETA
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_VNEG,
		ST_VHIGH,
		ST_SAT
	} status_t;

	typedef struct packed {
		logic    vld;
		status_t st;
	} ctl_t;

	// log2 unit
	localparam int LOG_TABLE_BITS = 6;
	localparam int LOG_QF         = 30;
	localparam int LOG_REM_W      = LOG_QF - LOG_TABLE_BITS;
	localparam int LOG_ENTRIES    = (1 << LOG_TABLE_BITS) + 1;
	localparam int LOG_IDX_W      = LOG_TABLE_BITS + 1;
	localparam int LOG_IN_W       = 51;
	localparam int LOG_E_W        = $clog2(LOG_IN_W);
	localparam int LOG_OUT_W      = LOG_E_W + LOG_QF;
	localparam int LOG_LAT        = 4;

	typedef logic [LOG_QF:0] log_rom_t [LOG_ENTRIES];

	// log2(1 + i/2^bits) in Q.30 by repeated squaring
	function automatic log_rom_t build_log_rom();
		log_rom_t    rom;
		logic [63:0] y;
		logic [63:0] r;
		for (int i = 0; i < LOG_ENTRIES; i++) begin
			if (i == (1 << LOG_TABLE_BITS)) begin
				rom[i] = (LOG_QF + 1)'(1) << LOG_QF;
			end else begin
				y = 64'((1 << LOG_TABLE_BITS) + i) << (LOG_QF - LOG_TABLE_BITS);
				r = '0;
				for (int k = 0; k < LOG_QF; k++) begin
					y = (y * y) >> LOG_QF;
					r = r << 1;
					if (y >= (64'd2 << LOG_QF)) begin
						y = y >> 1;
						r = r | 64'd1;
					end
				end
				rom[i] = r[LOG_QF:0];
			end
		end
		return rom;
	endfunction

	localparam log_rom_t LOG_ROM = build_log_rom();

endpackage

// ----- src/ntc_log2.sv -----
module ntc_log2 (
	input  logic                          clk,
	input  logic [ntc_pkg::LOG_IN_W-1:0]  x,
	output logic [ntc_pkg::LOG_OUT_W-1:0] y
);
	import ntc_pkg::*;

	localparam int PR_W = LOG_QF + 1 + LOG_REM_W;

	logic [LOG_E_W-1:0]        e_in;
	logic [LOG_IN_W-1:0]       x_s1;
	logic [LOG_E_W-1:0]        e_s1;
	logic [LOG_IN_W-1:0]       nx;
	logic [LOG_QF-1:0]         frac;
	logic [LOG_TABLE_BITS-1:0] idx_s2;
	logic [LOG_REM_W-1:0]      rem_s2;
	logic [LOG_E_W-1:0]        e_s2;
	logic [LOG_IDX_W-1:0]      ia;
	logic [LOG_IDX_W-1:0]      ib;
	logic [LOG_QF:0]           t0;
	logic [LOG_QF:0]           t1;
	logic [LOG_QF:0]           t0_s3;
	logic [LOG_QF:0]           diff_s3;
	logic [LOG_REM_W-1:0]      rem_s3;
	logic [LOG_E_W-1:0]        e_s3;
	logic [PR_W-1:0]           prod;
	logic [LOG_OUT_W-1:0]      y_s4;

	// msb search
	always_comb begin
		e_in = '0;
		for (int i = 0; i < LOG_IN_W; i++) begin
			if (x[i]) begin
				e_in = LOG_E_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		x_s1 <= x;
		e_s1 <= e_in;
	end

	// normalize so the leading one sits at the top
	always_comb begin
		nx   = x_s1 << (LOG_E_W'(LOG_IN_W - 1) - e_s1);
		frac = nx[LOG_IN_W-2 -: LOG_QF];
	end

	always_ff @(posedge clk) begin
		idx_s2 <= frac[LOG_QF-1 -: LOG_TABLE_BITS];
		rem_s2 <= frac[LOG_REM_W-1:0];
		e_s2   <= e_s1;
	end

	always_comb begin
		ia = {1'b0, idx_s2};
		ib = ia + LOG_IDX_W'(1);
		t0 = LOG_ROM[ia];
		t1 = LOG_ROM[ib];
	end

	always_ff @(posedge clk) begin
		t0_s3   <= t0;
		diff_s3 <= (t1 > t0) ? t1 - t0 : '0;
		rem_s3  <= rem_s2;
		e_s3    <= e_s2;
	end

	assign prod = PR_W'(diff_s3) * PR_W'(rem_s3);

	always_ff @(posedge clk) begin
		y_s4 <= {e_s3, LOG_QF'(0)} + LOG_OUT_W'(t0_s3) + LOG_OUT_W'(prod >> LOG_REM_W);
	end

	assign y = y_s4;

endmodule

// ----- src/thermistor_divider_to_temperature.sv -----
// throughput: one sample per clock, busy stays low; the three restoring dividers
// (one quotient bit per stage, 51 + 47 + 17 stages) set the depth
// the receiver cannot stall: each result is shown for one cycle only
// reset clears the valid pipeline and loads the default register values
module thermistor_divider_to_temperature (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic signed [15:0]             raw_sample,
	input  logic                           cfg_we,
	input  logic [ntc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ntc_pkg::CFG_W-1:0]      cfg_wdata,
	output logic                           done,
	output logic signed [15:0]             temperature_centi,
	output logic [1:0]                     status
);
	import ntc_pkg::*;

	localparam int P_W    = 28;
	localparam int PV_W   = 38;
	localparam int V_W    = 23;
	localparam int NUM_W  = 43;
	localparam int D1_NW  = 51;
	localparam int D1_RW  = 24;
	localparam int D1_AW  = D1_NW + D1_RW;
	localparam int D_W    = LOG_OUT_W + 1;
	localparam int PR_W   = 60;
	localparam int D2_NW  = 47;
	localparam int D2_RW  = 14;
	localparam int D2_AW  = D2_NW + D2_RW;
	localparam int INV_W  = 49;
	localparam int DEN3_W = 48;
	localparam int D3_NW  = 17;
	localparam int D3_RW  = 49;
	localparam int D3_AW  = D3_NW + D3_RW;

	localparam int D1_END  = 4 + D1_NW;
	localparam int LOG_END = D1_END + LOG_LAT;
	localparam int D2_BEG  = LOG_END + 3;
	localparam int D2_END  = D2_BEG + D2_NW;
	localparam int D3_BEG  = D2_END + 4;
	localparam int NST     = D3_BEG + D3_NW;

	localparam logic [23:0] LN2_Q24 = 24'd11629080;
	localparam logic signed [INV_W-1:0] INV_T0 =
		INV_W'(((64'd1 << 40) * 64'd100 + 64'd14907) / 64'd29815);
	localparam logic [63:0] N3_BASE   = 64'd100 << 40;
	localparam logic [63:0] INV_SCALE = 64'd27315;
	localparam logic signed [15:0] TEMP_MAX = 16'sh7fff;
	localparam logic signed [15:0] TEMP_MIN = 16'sh8000;

	// config registers
	logic [MV_W-1:0]  full_scale_mv_q;
	logic [MV_W-1:0]  supply_mv_q;
	logic [OHM_W-1:0] series_ohms_q;
	logic [OHM_W-1:0] nominal_ohms_q;
	logic [MV_W-1:0]  beta_kelvin_q;

	logic [V_W-1:0]   sup_uv;
	logic [OHM_W-1:0] nom_eff;
	logic [MV_W-1:0]  beta_eff;

	ctl_t ctl_s [1:NST];

	status_t st_volt;
	status_t st_res;
	status_t st_inv;

	logic [P_W-1:0]   p_s1;
	logic [V_W-1:0]   v_s2;
	logic [V_W-1:0]   v_s3;
	logic [V_W-1:0]   diff_s3;
	logic [NUM_W-1:0] num_s4;
	logic [V_W-1:0]   v_s4;

	logic [D1_AW-1:0] d1_in;
	logic [D1_AW-1:0] d1_acc_s [1:D1_NW];
	logic [V_W-1:0]   d1_den_s [1:D1_NW];

	logic [LOG_OUT_W-1:0] lr;
	logic [LOG_OUT_W-1:0] lnom;

	logic signed [D_W-1:0] d_s60;
	logic [LOG_OUT_W-1:0]  d_abs;
	logic [PR_W-1:0]       prod_s61;
	logic                  neg_s61;
	logic [D2_NW-1:0]      n2_s62;
	logic                  neg_s62;

	logic [D2_AW-1:0] d2_acc_s [1:D2_NW];
	logic             d2_neg_s [1:D2_NW];
	logic [D2_NW-1:0] q2;

	logic signed [INV_W-1:0] inv_s110;
	logic [63:0]             n3_s111;
	logic [DEN3_W-1:0]       den_s111;
	logic [63:0]             n3_abs;
	logic [63:0]             a3_s112;
	logic [DEN3_W-1:0]       den_s112;
	logic                    neg_s112;
	logic [63:0]             a3_s113;
	logic [DEN3_W-1:0]       den_s113;
	logic                    neg_s113;
	logic                    ovf_s113;

	logic [D3_AW-1:0]  d3_acc_s [1:D3_NW];
	logic [DEN3_W-1:0] d3_den_s [1:D3_NW];
	logic              d3_neg_s [1:D3_NW];
	logic              d3_ovf_s [1:D3_NW];
	logic [D3_NW-1:0]  q3;

	status_t            st_fin;
	logic signed [15:0] temp_fin;
	logic               done_s131;
	status_t            status_s131;
	logic signed [15:0] temp_s131;

	function automatic logic [D1_AW-1:0] d1_step(input logic [D1_AW-1:0] acc,
			input logic [V_W-1:0] den);
		logic [D1_AW-1:0] t;
		t = acc << 1;
		if (t[D1_AW-1 -: D1_RW] >= D1_RW'(den)) begin
			t[D1_AW-1 -: D1_RW] = t[D1_AW-1 -: D1_RW] - D1_RW'(den);
			t[0] = 1'b1;
		end
		return t;
	endfunction

	function automatic logic [D2_AW-1:0] d2_step(input logic [D2_AW-1:0] acc,
			input logic [MV_W-1:0] den);
		logic [D2_AW-1:0] t;
		t = acc << 1;
		if (t[D2_AW-1 -: D2_RW] >= D2_RW'(den)) begin
			t[D2_AW-1 -: D2_RW] = t[D2_AW-1 -: D2_RW] - D2_RW'(den);
			t[0] = 1'b1;
		end
		return t;
	endfunction

	function automatic logic [D3_AW-1:0] d3_step(input logic [D3_AW-1:0] acc,
			input logic [DEN3_W-1:0] den);
		logic [D3_AW-1:0] t;
		t = acc << 1;
		if (t[D3_AW-1 -: D3_RW] >= D3_RW'(den)) begin
			t[D3_AW-1 -: D3_RW] = t[D3_AW-1 -: D3_RW] - D3_RW'(den);
			t[0] = 1'b1;
		end
		return t;
	endfunction

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_scale_mv_q <= FULL_SCALE_RST;
			supply_mv_q     <= SUPPLY_RST;
			series_ohms_q   <= SERIES_RST;
			nominal_ohms_q  <= NOMINAL_RST;
			beta_kelvin_q   <= BETA_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FULL_SCALE: full_scale_mv_q <= cfg_wdata[MV_W-1:0];
				CFG_SUPPLY:     supply_mv_q     <= cfg_wdata[MV_W-1:0];
				CFG_SERIES:     series_ohms_q   <= cfg_wdata[OHM_W-1:0];
				CFG_NOMINAL:    nominal_ohms_q  <= cfg_wdata[OHM_W-1:0];
				CFG_BETA:       beta_kelvin_q   <= cfg_wdata[MV_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		sup_uv   = V_W'(supply_mv_q) * V_W'(1000);
		nom_eff  = (nominal_ohms_q == '0) ? OHM_W'(1) : nominal_ohms_q;
		beta_eff = (beta_kelvin_q == '0) ? MV_W'(1) : beta_kelvin_q;
	end

	always_comb begin
		st_volt = ctl_s[2].st;
		if (ctl_s[2].st == ST_OK) begin
			if (v_s2 <= V_W'(1)) begin
				st_volt = ST_VNEG;
			end else if (v_s2 >= sup_uv) begin
				st_volt = ST_VHIGH;
			end
		end
		// resistance rounded to zero
		st_res = ctl_s[D1_END].st;
		if (ctl_s[D1_END].st == ST_OK && d1_acc_s[D1_NW][D1_NW-1:0] == '0) begin
			st_res = ST_VHIGH;
		end
		st_inv = ctl_s[D2_END+1].st;
		if (ctl_s[D2_END+1].st == ST_OK && (inv_s110[INV_W-1] || inv_s110 == '0)) begin
			st_inv = ST_SAT;
		end
	end

	// valid and status travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= NST; i++) begin
				ctl_s[i] <= '{vld: 1'b0, st: ST_OK};
			end
		end else begin
			ctl_s[1] <= '{vld: start && !busy,
				st: (raw_sample == '0 || raw_sample[15]) ? ST_VNEG : ST_OK};
			for (int i = 1; i < NST; i++) begin
				if (i == 2) begin
					ctl_s[i+1] <= '{vld: ctl_s[i].vld, st: st_volt};
				end else if (i == D1_END) begin
					ctl_s[i+1] <= '{vld: ctl_s[i].vld, st: st_res};
				end else if (i == D2_END + 1) begin
					ctl_s[i+1] <= '{vld: ctl_s[i].vld, st: st_inv};
				end else begin
					ctl_s[i+1] <= ctl_s[i];
				end
			end
		end
	end

	// front end: voltage and divider numerator
	always_ff @(posedge clk) begin
		p_s1    <= P_W'(raw_sample[14:0]) * P_W'(full_scale_mv_q);
		v_s2    <= V_W'((PV_W'(p_s1) * PV_W'(1000) + PV_W'(16384)) >> 15);
		v_s3    <= v_s2;
		diff_s3 <= sup_uv - v_s2;
		num_s4  <= NUM_W'(series_ohms_q) * NUM_W'(diff_s3);
		v_s4    <= v_s3;
	end

	assign d1_in = {D1_RW'(0), (D1_NW'(num_s4) << 8) + D1_NW'(v_s4 >> 1)};

	always_ff @(posedge clk) begin
		d1_acc_s[1] <= d1_step(d1_in, v_s4);
		d1_den_s[1] <= v_s4;
		for (int k = 1; k < D1_NW; k++) begin
			d1_acc_s[k+1] <= d1_step(d1_acc_s[k], d1_den_s[k]);
			d1_den_s[k+1] <= d1_den_s[k];
		end
	end

	ntc_log2 u_log_r (
		.clk (clk),
		.x   (d1_acc_s[D1_NW][D1_NW-1:0]),
		.y   (lr)
	);

	// nominal term follows the register, settled long before an item gets here
	ntc_log2 u_log_nom (
		.clk (clk),
		.x   (LOG_IN_W'({nom_eff, 8'b0})),
		.y   (lnom)
	);

	assign d_abs = d_s60[D_W-1] ? LOG_OUT_W'(-d_s60) : LOG_OUT_W'(d_s60);

	always_ff @(posedge clk) begin
		d_s60    <= $signed({1'b0, lr}) - $signed({1'b0, lnom});
		prod_s61 <= PR_W'(d_abs) * PR_W'(LN2_Q24);
		neg_s61  <= d_s60[D_W-1];
		// rounding by beta << 14 folds into a shift plus a divide by beta
		n2_s62   <= D2_NW'((61'(prod_s61) + (61'(beta_eff) << 13)) >> 14);
		neg_s62  <= neg_s61;
	end

	always_ff @(posedge clk) begin
		d2_acc_s[1] <= d2_step({D2_RW'(0), n2_s62}, beta_eff);
		d2_neg_s[1] <= neg_s62;
		for (int k = 1; k < D2_NW; k++) begin
			d2_acc_s[k+1] <= d2_step(d2_acc_s[k], beta_eff);
			d2_neg_s[k+1] <= d2_neg_s[k];
		end
	end

	assign q2     = d2_acc_s[D2_NW][D2_NW-1:0];
	assign n3_abs = n3_s111[63] ? -n3_s111 : n3_s111;

	always_ff @(posedge clk) begin
		inv_s110 <= INV_T0 + (d2_neg_s[D2_NW] ? -INV_W'(q2) : INV_W'(q2));
		n3_s111  <= N3_BASE - INV_SCALE * 64'(inv_s110[DEN3_W-1:0]);
		den_s111 <= inv_s110[DEN3_W-1:0];
		a3_s112  <= n3_abs + 64'(den_s111 >> 1);
		den_s112 <= den_s111;
		neg_s112 <= n3_s111[63];
		// quotient needs more than 17 bits: saturated anyway
		ovf_s113 <= DEN3_W'(a3_s112[63:D3_NW]) >= den_s112;
		a3_s113  <= a3_s112;
		den_s113 <= den_s112;
		neg_s113 <= neg_s112;
	end

	always_ff @(posedge clk) begin
		d3_acc_s[1] <= d3_step({2'b0, a3_s113}, den_s113);
		d3_den_s[1] <= den_s113;
		d3_neg_s[1] <= neg_s113;
		d3_ovf_s[1] <= ovf_s113;
		for (int k = 1; k < D3_NW; k++) begin
			d3_acc_s[k+1] <= d3_step(d3_acc_s[k], d3_den_s[k]);
			d3_den_s[k+1] <= d3_den_s[k];
			d3_neg_s[k+1] <= d3_neg_s[k];
			d3_ovf_s[k+1] <= d3_ovf_s[k];
		end
	end

	assign q3 = d3_acc_s[D3_NW][D3_NW-1:0];

	always_comb begin
		st_fin   = ctl_s[NST].st;
		temp_fin = '0;
		case (ctl_s[NST].st) inside
			ST_VNEG, ST_VHIGH: temp_fin = '0;
			ST_SAT:            temp_fin = TEMP_MAX;
			ST_OK: begin
				if (d3_neg_s[D3_NW]) begin
					if (d3_ovf_s[D3_NW] || q3 > D3_NW'(32768)) begin
						temp_fin = TEMP_MIN;
						st_fin   = ST_SAT;
					end else begin
						temp_fin = -$signed(16'(q3));
					end
				end else begin
					if (d3_ovf_s[D3_NW] || q3 > D3_NW'(32767)) begin
						temp_fin = TEMP_MAX;
						st_fin   = ST_SAT;
					end else begin
						temp_fin = $signed(16'(q3));
					end
				end
			end
			default: temp_fin = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s131 <= 1'b0;
		end else begin
			done_s131 <= ctl_s[NST].vld;
		end
	end

	always_ff @(posedge clk) begin
		status_s131 <= st_fin;
		temp_s131   <= temp_fin;
	end

	assign done              = done_s131;
	assign status            = status_s131;
	assign temperature_centi = temp_s131;

	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, NST + 1))
		else $error("result beat without a sample");

	a_fault_zero_temp: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_VNEG || status == ST_VHIGH) |-> temperature_centi == '0)
		else $error("fault status with nonzero temperature");

	a_sat_at_rail: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_SAT |-> temperature_centi == TEMP_MAX ||
			temperature_centi == TEMP_MIN)
		else $error("saturated status off the rails");

	a_d1_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s[D1_END].vld && ctl_s[D1_END].st == ST_OK |->
			d1_acc_s[D1_NW][D1_AW-1 -: D1_RW] < D1_RW'(d1_den_s[D1_NW]))
		else $error("resistance divider remainder not below divisor");

endmodule
